>>> rtl/slp_pkg.sv
package slp_pkg;

    localparam int VALUE_W  = 32;
    localparam int REMOVE_W = 5;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FIN
    } t_state;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  entry_value;
        logic        [REMOVE_W-1:0] removed_count;
        logic        [STATUS_W-1:0] status;
        logic                       last;
    } t_result;

endpackage

>>> rtl/sorted_descending_list.sv
// channel    direction  handshake            payload
// command    in         i_valid / o_stall    i_command, i_value
// result     out        o_valid / i_stall    o_entry_value, o_removed_count, o_status, o_last
//
// insert and delete walk the stored entries through one ram read port,
// one entry per cycle
// a dump gives one result per cycle while the result side does not stall
// an empty list skips the walk; an unused command code is taken and gives no result
// reset clears the state, the entry count and the output valid; the entry ram is never cleared
module sorted_descending_list #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [slp_pkg::CMD_W-1:0]         i_command,
    input  logic signed [slp_pkg::VALUE_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [slp_pkg::VALUE_W-1:0] o_entry_value,
    output logic [slp_pkg::REMOVE_W-1:0]      o_removed_count,
    output logic [slp_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_last
);

    import slp_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state;
    t_state n_state;

    logic [CMD_W-1:0]          r_cmd;
    logic [CMD_W-1:0]          n_cmd;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;
    logic signed [VALUE_W-1:0] r_carry;
    logic signed [VALUE_W-1:0] n_carry;
    logic                      r_placed;
    logic                      n_placed;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             n_idx;
    logic [CW-1:0]             r_w;
    logic [CW-1:0]             n_w;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    logic                      accept;
    logic                      last_idx;
    logic                      full;
    logic [CW-1:0]             removed;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic signed [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic signed [VALUE_W-1:0] ram_rdata;

    logic                      out_load;
    logic                      out_free;
    t_result                   out_res;
    t_result                   res_q;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign last_idx = (CW'(r_idx + CW'(1)) == r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign removed  = CW'(r_count - r_w);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_INSERT || i_command == CMD_DELETE ||
                               i_command == CMD_DUMP)) begin
                    n_state = (r_count == '0) ? S_FIN : S_WALK;
                end
            end
            S_WALK: begin
                if (r_cmd == CMD_DUMP) begin
                    if (out_free && last_idx) begin
                        n_state = S_IDLE;
                    end
                end else if (last_idx) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd     = r_cmd;
        n_val     = r_val;
        n_carry   = r_carry;
        n_placed  = r_placed;
        n_idx     = r_idx;
        n_w       = r_w;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = r_val;
        out_load  = 1'b0;
        out_res   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_command;
                    n_val    = i_value;
                    n_placed = 1'b0;
                    n_idx    = '0;
                    n_w      = '0;
                end
            end
            S_WALK: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        n_idx = CW'(r_idx + CW'(1));
                        if (r_placed) begin
                            ram_we    = 1'b1;
                            ram_wdata = r_carry;
                            n_carry   = ram_rdata;
                        end else if (!(ram_rdata > r_val)) begin
                            ram_we    = 1'b1;
                            ram_wdata = r_val;
                            n_carry   = ram_rdata;
                            n_placed  = 1'b1;
                        end
                    end
                    CMD_DELETE: begin
                        n_idx = CW'(r_idx + CW'(1));
                        if (ram_rdata != r_val) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_w[AW-1:0];
                            ram_wdata = ram_rdata;
                            n_w       = CW'(r_w + CW'(1));
                        end
                    end
                    CMD_DUMP: begin
                        if (out_free) begin
                            out_load            = 1'b1;
                            out_res.entry_value = ram_rdata;
                            out_res.status      = ST_OK;
                            out_res.last        = last_idx;
                            n_idx               = CW'(r_idx + CW'(1));
                        end
                    end
                    default: ;
                endcase
            end
            S_FIN: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    out_res.last = 1'b1;
                    unique case (r_cmd)
                        CMD_INSERT: begin
                            if (full) begin
                                out_res.status = ST_OVERFLOW;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = r_placed ? r_carry : r_val;
                                n_count   = CW'(r_count + CW'(1));
                                out_res.status = ST_OK;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                out_res.status = ST_EMPTY;
                            end else begin
                                n_count               = r_w;
                                out_res.removed_count = REMOVE_W'(removed);
                                out_res.status        = ST_OK;
                            end
                        end
                        CMD_DUMP: begin
                            out_res.status = ST_EMPTY;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        ram_raddr = n_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_val    <= n_val;
        r_carry  <= n_carry;
        r_placed <= n_placed;
        r_idx    <= n_idx;
        r_w      <= n_w;
    end

    slp_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    slp_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (out_load),
        .i_res  (out_res),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_res  (res_q),
        .o_free (out_free)
    );

    assign o_entry_value   = res_q.entry_value;
    assign o_removed_count = res_q.removed_count;
    assign o_status        = res_q.status;
    assign o_last          = res_q.last;

endmodule

>>> rtl/slp_ram.sv
module slp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/slp_out_reg.sv
module slp_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  slp_pkg::t_result i_res,
    input  logic            i_stall,
    output logic            o_valid,
    output slp_pkg::t_result o_res,
    output logic            o_free
);

    import slp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

>>> dv/sorted_descending_list_test.sv
module sorted_descending_list_test;

    import slp_pkg::*;

    localparam int              LIST_CAPACITY = 16;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int              RANDOM_ITEMS  = 370;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] value;
        bit                        drain;
    } t_command_item;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [CMD_W-1:0]            i_command = '0;
    logic signed [VALUE_W-1:0]   i_value = '0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic signed [VALUE_W-1:0]   o_entry_value;
    logic [REMOVE_W-1:0]         o_removed_count;
    logic [STATUS_W-1:0]         o_status;
    logic                        o_last;

    t_command_item               pending_cmds[$];
    t_result                     expected_results[$];
    logic signed [VALUE_W-1:0]   score_list[$];
    int                          items_sent = 0;
    int                          error_count = 0;

    logic signed [VALUE_W-1:0]   value_pool[8] = '{
        32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
        32'sd1, 32'sd100, -32'sd100, 32'sh5555_5555
    };

    sorted_descending_list u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_entry_value   (o_entry_value),
        .o_removed_count (o_removed_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    // idle and stall rates per phase of the run
    function automatic int sender_idle_pct();
        if (items_sent < 150) return 30;
        if (items_sent < 290) return 79;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (items_sent < 150) return 79;
        if (items_sent < 290) return 30;
        return 0;
    endfunction

    // updates the list copy and queues the results a command causes
    task automatic apply_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [VALUE_W-1:0] val);
        int      pos;
        int      n_before;
        t_result r;
        r      = '0;
        r.last = 1'b1;
        case (cmd)
            CMD_INSERT: begin
                pos = 0;
                while (pos < score_list.size() && score_list[pos] > val)
                    pos++;
                if (score_list.size() >= LIST_CAPACITY) begin
                    r.status = ST_OVERFLOW;
                    if (pos < score_list.size()) begin
                        score_list.insert(pos, val);
                        void'(score_list.pop_back());
                    end
                end else begin
                    score_list.insert(pos, val);
                    r.status = ST_OK;
                end
                expected_results.push_back(r);
            end
            CMD_DELETE: begin
                if (score_list.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    n_before = score_list.size();
                    for (int i = score_list.size() - 1; i >= 0; i--)
                        if (score_list[i] == val)
                            score_list.delete(i);
                    r.removed_count = REMOVE_W'(n_before - score_list.size());
                    r.status        = ST_OK;
                end
                expected_results.push_back(r);
            end
            CMD_DUMP: begin
                if (score_list.size() == 0) begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end else begin
                    foreach (score_list[i]) begin
                        r.entry_value = score_list[i];
                        r.status      = ST_OK;
                        r.last        = (i == score_list.size() - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint exp_val,
                               input longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive
        logic          nxt_valid;
        t_command_item item;
        nxt_valid = i_valid;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                apply_command(i_command, i_value);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_cmds.size() > 0
                    && $urandom_range(99) >= sender_idle_pct()
                    && (!pending_cmds[0].drain || expected_results.size() == 0)) begin
                item = pending_cmds.pop_front();
                i_command  <= item.cmd;
                i_value    <= item.value;
                items_sent <= items_sent + 1;
                nxt_valid  = 1'b1;
            end
        end
        i_valid <= nxt_valid;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < receiver_stall_pct());
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_result exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, entry_value %0d status %0d last %0d",
                         $time, o_entry_value, o_status, o_last);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("entry_value", exp_r.entry_value, o_entry_value);
                check_field("removed_count", exp_r.removed_count, o_removed_count);
                check_field("status", exp_r.status, o_status);
                check_field("last", exp_r.last, o_last);
            end
        end
    end

    function automatic void push_cmd(input logic [CMD_W-1:0] cmd,
                                     input logic signed [VALUE_W-1:0] val,
                                     input bit drain = 1'b0);
        t_command_item item;
        item.cmd   = cmd;
        item.value = val;
        item.drain = drain;
        pending_cmds.push_back(item);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 70) return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return CMD_INSERT;
        if (roll < 75) return CMD_DELETE;
        if (roll < 95) return CMD_DUMP;
        return CMD_UNUSED;
    endfunction

    // stimulus and end of run
    initial begin : stimulus
        int                        n_random;
        int                        next_drain;
        int                        kind;
        int                        reps;
        logic [CMD_W-1:0]          cmd;
        logic signed [VALUE_W-1:0] v;

        // directed
        push_cmd(CMD_DUMP, 32'sd0);
        push_cmd(CMD_DELETE, 32'sd5);
        push_cmd(CMD_UNUSED, $urandom);
        push_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        push_cmd(CMD_INSERT, 32'sd0);
        push_cmd(CMD_INSERT, 32'sd0);
        push_cmd(CMD_INSERT, -32'sd1);
        push_cmd(CMD_DUMP, $urandom);
        push_cmd(CMD_DELETE, 32'sd0);
        push_cmd(CMD_DELETE, 32'sd7);
        for (int k = 0; k < 14; k++)
            push_cmd(CMD_INSERT, k * 7 - 40);
        push_cmd(CMD_INSERT, 32'sh8000_0000);
        push_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        push_cmd(CMD_DUMP, 32'sd0);

        // random episodes
        n_random   = 0;
        next_drain = 0;
        while (n_random < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (n_random >= next_drain) begin
                push_cmd(CMD_DUMP, $urandom, 1'b1);
                n_random++;
                next_drain += 100;
            end
            if (kind < 70) begin
                for (int k = 0; k < 20; k++) begin
                    cmd = pick_cmd();
                    push_cmd(cmd, pick_value());
                    if (cmd != CMD_UNUSED) n_random++;
                end
            end else if (kind < 88) begin
                // fill with one score, then remove it all
                v    = pick_value();
                reps = $urandom_range(14, 18);
                for (int k = 0; k < reps; k++)
                    push_cmd(CMD_INSERT, v);
                push_cmd(CMD_DUMP, $urandom);
                push_cmd(CMD_DELETE, v);
                n_random += reps + 2;
            end else begin
                // sweep the pool values out of the list
                foreach (value_pool[i])
                    push_cmd(CMD_DELETE, value_pool[i]);
                push_cmd(CMD_DUMP, $urandom);
                push_cmd(CMD_DELETE, $urandom);
                n_random += 10;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
